@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL of the header line classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Same-cycle check failed.");

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Next-cycle check failed.");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/mhlc_pkg.sv @@
// Package with the field name table and byte class functions of the header line classifier.
package mhlc_pkg;

	localparam int NUM_NAMES = 5;
	localparam int NAME_CHARS = 8;
	localparam int NUM_FLAGS = 5;
	localparam logic [3:0] NAME_LEN_MAX = 4'd15;

	typedef logic [NUM_NAMES-1:0] match_t;
	typedef logic [NUM_FLAGS-1:0] flags_t;

	localparam logic [7:0] COLON = 8'h3A;

	localparam logic [7:0] NAME_TEXT [NUM_NAMES][NAME_CHARS] = '{
		'{8'h66, 8'h72, 8'h6F, 8'h6D, 8'h3A, 8'h00, 8'h00, 8'h00},
		'{8'h73, 8'h75, 8'h62, 8'h6A, 8'h65, 8'h63, 8'h74, 8'h3A},
		'{8'h74, 8'h6F, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h63, 8'h63, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h62, 8'h63, 8'h63, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd5, 4'd8, 4'd3, 4'd3, 4'd4};

	// Flag bits: from, subject, recipient, to, cc (low to high).
	localparam flags_t NAME_FLAGS [NUM_NAMES] = '{
		5'b00001, 5'b00010, 5'b01100, 5'b10100, 5'b00100
	};

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_ctl(input logic [7:0] c);
		return (c < 8'h20) || (c == 8'h7F);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= 8'h20) && (c <= 8'h7E);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
	endfunction

endpackage

@@ sv/mail_header_line_classifier.sv @@
// Top level of the mail header line classifier: input register, line state and result register.
//
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   ch, line_last, first_mark, new_message
// result    out        out_valid/out_stall rejected, from_seen, subject_seen,
//                                          recipient_seen, to_seen, cc_seen
//
// One character is taken per cycle while in_stall is low; its request lands in the input register and
// updates the line state from there, and the result register takes the verdict and flags when the last
// character of a line leaves the input register.
// Reset clears the line state and the sticky flags and empties both registers.
// A stall on the result side holds the input only when a finished line waits for
// a full result register; other characters keep flowing.
`include "assert_macros.svh"

module mail_header_line_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       line_last,
	input  logic       first_mark,
	input  logic       new_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       rejected,
	output logic       from_seen,
	output logic       subject_seen,
	output logic       recipient_seen,
	output logic       to_seen,
	output logic       cc_seen
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       mark_s1;
	logic       newmsg_s1;

	logic                 mid_line_q;
	logic                 decided_q;
	logic                 verdict_q;
	logic [3:0]           name_len_q;
	mhlc_pkg::match_t     match_q;
	logic                 colon_q;
	mhlc_pkg::flags_t     flags_q;

	logic                 mid_line_d;
	logic                 decided_d;
	logic                 verdict_d;
	logic [3:0]           name_len_d;
	mhlc_pkg::match_t     match_d;
	logic                 colon_d;
	mhlc_pkg::flags_t     flags_d;
	logic                 finish;
	logic                 name_step;
	logic                 advance;
	mhlc_pkg::flags_t     pick;

	logic                 out_valid_q;
	logic                 rejected_q;
	mhlc_pkg::flags_t     out_flags_q;

	logic                 in_take;
	logic                 step;

	assign step     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		mid_line_d = mid_line_q;
		decided_d  = decided_q;
		verdict_d  = verdict_q;
		name_len_d = name_len_q;
		match_d    = match_q;
		colon_d    = colon_q;
		flags_d    = newmsg_s1 ? '0 : flags_q;
		finish     = 1'b0;
		name_step  = 1'b0;
		advance    = 1'b0;
		pick       = '0;

		if (!mid_line_q) begin
			mid_line_d = 1'b1;
			if (mhlc_pkg::is_ws(ch_s1)) begin
				decided_d = 1'b1;
				verdict_d = mark_s1;
			end else if ((ch_s1 == mhlc_pkg::COLON) || !mhlc_pkg::is_print(ch_s1)) begin
				decided_d = 1'b1;
				verdict_d = 1'b1;
			end else begin
				name_step = 1'b1;
			end
		end else if (!decided_q) begin
			name_step = 1'b1;
		end

		if (name_step) begin
			if (colon_q && mhlc_pkg::is_ws(ch_s1)) begin
				finish = 1'b1;
			end else begin
				colon_d = 1'b0;
				if (mhlc_pkg::is_ctl(ch_s1) || mhlc_pkg::is_ws(ch_s1)) begin
					decided_d = 1'b1;
					verdict_d = 1'b1;
				end else begin
					advance = 1'b1;
					colon_d = (ch_s1 == mhlc_pkg::COLON);
				end
			end
		end

		if (advance) begin
			for (int k = 0; k < mhlc_pkg::NUM_NAMES; k++) begin
				if ((name_len_q >= mhlc_pkg::NAME_LEN[k]) ||
				    (mhlc_pkg::fold(ch_s1) != mhlc_pkg::NAME_TEXT[k][name_len_q[2:0]])) begin
					match_d[k] = 1'b0;
				end
			end
			if (name_len_q != mhlc_pkg::NAME_LEN_MAX) begin
				name_len_d = name_len_q + 4'd1;
			end
		end

		if (last_s1 && !decided_d) begin
			if (colon_d) begin
				finish = 1'b1;
			end else begin
				decided_d = 1'b1;
				verdict_d = 1'b1;
			end
		end

		if (finish) begin
			for (int k = mhlc_pkg::NUM_NAMES - 1; k >= 0; k--) begin
				if (match_d[k]) begin
					pick = mhlc_pkg::NAME_FLAGS[k];
				end
			end
			flags_d   = flags_d | pick;
			decided_d = 1'b1;
			verdict_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1     <= ch;
			last_s1   <= line_last;
			mark_s1   <= first_mark;
			newmsg_s1 <= new_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_line_q <= 1'b0;
			decided_q  <= 1'b0;
			verdict_q  <= 1'b0;
			name_len_q <= '0;
			match_q    <= '1;
			colon_q    <= 1'b0;
			flags_q    <= '0;
		end else if (step) begin
			flags_q <= flags_d;
			if (last_s1) begin
				mid_line_q <= 1'b0;
				decided_q  <= 1'b0;
				verdict_q  <= 1'b0;
				name_len_q <= '0;
				match_q    <= '1;
				colon_q    <= 1'b0;
			end else begin
				mid_line_q <= mid_line_d;
				decided_q  <= decided_d;
				verdict_q  <= verdict_d;
				name_len_q <= name_len_d;
				match_q    <= match_d;
				colon_q    <= colon_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			rejected_q  <= verdict_d;
			out_flags_q <= flags_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign rejected       = rejected_q;
	assign from_seen      = out_flags_q[0];
	assign subject_seen   = out_flags_q[1];
	assign recipient_seen = out_flags_q[2];
	assign to_seen        = out_flags_q[3];
	assign cc_seen        = out_flags_q[4];

	`ASSERT_SAME_CYCLE(a_stall_only_on_full_result, clk, arst_n, in_stall, valid_s1 && last_s1 && out_valid_q && out_stall)
	`ASSERT_NEXT_CYCLE(a_line_end_gives_result, clk, arst_n, step && last_s1, out_valid_q)
	`ASSERT_SAME_CYCLE(a_match_needs_short_name, clk, arst_n, match_q != '0, name_len_q <= 4'd8)
	`ASSERT_SAME_CYCLE(a_idle_line_is_clear, clk, arst_n, !mid_line_q, !decided_q && !verdict_q && !colon_q && (name_len_q == '0) && (match_q == '1))

endmodule

@@ tb/mhlc_line_checker.sv @@
// Checker that predicts each header line verdict of the classifier and compares it with the result.
`timescale 1ns / 100ps

module mhlc_line_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] ch,
	input  logic       line_last,
	input  logic       first_mark,
	input  logic       new_message,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       rejected,
	input  logic       from_seen,
	input  logic       subject_seen,
	input  logic       recipient_seen,
	input  logic       to_seen,
	input  logic       cc_seen,
	output int         fail_count,
	output int         lines_open
);

	typedef enum int {KEY_FROM, KEY_SUBJECT, KEY_TO, KEY_CC, KEY_BCC, KEY_COUNT} key_t;

	localparam logic [4:0] SEEN_FROM    = 5'b00001;
	localparam logic [4:0] SEEN_SUBJECT = 5'b00010;
	localparam logic [4:0] SEEN_RCPT    = 5'b00100;
	localparam logic [4:0] SEEN_TO      = 5'b01000;
	localparam logic [4:0] SEEN_CC      = 5'b10000;
	localparam logic [3:0] NAME_CAP     = 4'd15;

	typedef struct packed {
		logic       rejected;
		logic [4:0] seen;
	} line_verdict_t;

	logic          in_line;
	logic          settled;
	logic          bad;
	logic [3:0]    name_len;
	logic [4:0]    alive;
	logic          colon_open;
	logic [4:0]    seen;
	line_verdict_t line_verdicts [$];

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_control(input logic [7:0] c);
		return (c < 8'h20) || (c == 8'h7F);
	endfunction

	function automatic logic is_printable(input logic [7:0] c);
		return (c >= 8'h20) && (c <= 8'h7E);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int key_length(input int k);
		case (k)
			KEY_FROM:    return 5;
			KEY_SUBJECT: return 8;
			KEY_TO:      return 3;
			KEY_CC:      return 3;
			default:     return 4;
		endcase
	endfunction

	function automatic logic [7:0] key_byte(input int k, input int p);
		logic [63:0] text;
		case (k)
			KEY_FROM:    text = "from:";
			KEY_SUBJECT: text = "subject:";
			KEY_TO:      text = "to:";
			KEY_CC:      text = "cc:";
			default:     text = "bcc:";
		endcase
		return text[8 * (key_length(k) - 1 - p) +: 8];
	endfunction

	function automatic logic [4:0] key_flags(input int k);
		case (k)
			KEY_FROM:    return SEEN_FROM;
			KEY_SUBJECT: return SEEN_SUBJECT;
			KEY_TO:      return SEEN_RCPT | SEEN_TO;
			KEY_CC:      return SEEN_RCPT | SEEN_CC;
			default:     return SEEN_RCPT;
		endcase
	endfunction

	function automatic void clear_line();
		in_line = 1'b0;
		settled = 1'b0;
		bad = 1'b0;
		name_len = '0;
		alive = '1;
		colon_open = 1'b0;
	endfunction

	function automatic void grow_name(input logic [7:0] c);
		int k;
		for (k = 0; k < KEY_COUNT; k++) begin
			if (name_len >= key_length(k) || to_lower(c) != key_byte(k, name_len))
				alive[k] = 1'b0;
		end
		if (name_len != NAME_CAP)
			name_len = name_len + 4'd1;
	endfunction

	// The first candidate still alive wins; the order of the keys matters here.
	function automatic void close_name();
		int k;
		logic hit;
		hit = 1'b0;
		for (k = 0; k < KEY_COUNT; k++) begin
			if (!hit && alive[k]) begin
				seen = seen | key_flags(k);
				hit = 1'b1;
			end
		end
		settled = 1'b1;
		bad = 1'b0;
	endfunction

	function automatic void name_char(input logic [7:0] c);
		if (colon_open) begin
			if (is_blank(c)) begin
				close_name();
				return;
			end
			colon_open = 1'b0;
		end
		if (is_control(c)) begin
			settled = 1'b1;
			bad = 1'b1;
		end else if (c == mhlc_pkg::COLON) begin
			grow_name(c);
			colon_open = 1'b1;
		end else if (is_blank(c)) begin
			settled = 1'b1;
			bad = 1'b1;
		end else begin
			grow_name(c);
		end
	endfunction

	function automatic void classify_char();
		if (new_message)
			seen = '0;
		if (!in_line) begin
			in_line = 1'b1;
			if (is_blank(ch)) begin
				settled = 1'b1;
				bad = first_mark;
			end else if (ch == mhlc_pkg::COLON || !is_printable(ch)) begin
				settled = 1'b1;
				bad = 1'b1;
			end else begin
				name_char(ch);
			end
		end else if (!settled) begin
			name_char(ch);
		end
		if (line_last) begin
			if (!settled) begin
				if (colon_open) begin
					close_name();
				end else begin
					settled = 1'b1;
					bad = 1'b1;
				end
			end
			line_verdicts.push_back('{rejected: bad, seen: seen});
			clear_line();
		end
	endfunction

	function automatic void compare_bit(input string field, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", field, want, got);
			fail_count++;
		end
	endfunction

	function automatic void check_result();
		line_verdict_t want;
		if (line_verdicts.size() == 0) begin
			$error("Result with no line waiting: rejected %0b.", rejected);
			fail_count++;
			return;
		end
		want = line_verdicts.pop_front();
		compare_bit("rejected", want.rejected, rejected);
		compare_bit("from_seen", want.seen[0], from_seen);
		compare_bit("subject_seen", want.seen[1], subject_seen);
		compare_bit("recipient_seen", want.seen[2], recipient_seen);
		compare_bit("to_seen", want.seen[3], to_seen);
		compare_bit("cc_seen", want.seen[4], cc_seen);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			seen = '0;
			line_verdicts.delete();
			fail_count = 0;
			lines_open = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				classify_char();
			lines_open = line_verdicts.size();
		end
	end

endmodule

@@ tb/tb_mail_header_line_classifier.sv @@
// Testbench top of the mail header line classifier: clock, reset, character stimulus and verdict.
`timescale 1ns / 100ps

module tb_mail_header_line_classifier;

	localparam int CHAR_TARGET = 825;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 34;
	localparam int QUIET_FROM = 300;
	localparam int QUIET_TO = 450;
	localparam int NO_NEW_MESSAGE = -1;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = '0;
	logic       line_last = 1'b0;
	logic       first_mark = 1'b0;
	logic       new_message = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       rejected;
	logic       from_seen;
	logic       subject_seen;
	logic       recipient_seen;
	logic       to_seen;
	logic       cc_seen;

	int         fail_count;
	int         lines_open;
	int         chars_sent = 0;
	int         cycles = 0;
	logic       quiet = 1'b0;
	logic [7:0] line_buf [$];

	mail_header_line_classifier u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ch            (ch),
		.line_last     (line_last),
		.first_mark    (first_mark),
		.new_message   (new_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rejected      (rejected),
		.from_seen     (from_seen),
		.subject_seen  (subject_seen),
		.recipient_seen(recipient_seen),
		.to_seen       (to_seen),
		.cc_seen       (cc_seen)
	);

	mhlc_line_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ch            (ch),
		.line_last     (line_last),
		.first_mark    (first_mark),
		.new_message   (new_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rejected      (rejected),
		.from_seen     (from_seen),
		.subject_seen  (subject_seen),
		.recipient_seen(recipient_seen),
		.to_seen       (to_seen),
		.cc_seen       (cc_seen),
		.fail_count    (fail_count),
		.lines_open    (lines_open)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic put_char(input logic [7:0] c, input logic last, input logic mark,
			input logic fresh);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		ch = c;
		line_last = last;
		first_mark = mark;
		new_message = fresh;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	// The first mark only counts on the first character; later ones carry noise.
	task automatic send_line(input logic mark, input int fresh_at);
		int i;
		for (i = 0; i < line_buf.size(); i++)
			put_char(line_buf[i], i == line_buf.size() - 1,
				(i == 0) ? mark : 1'($urandom_range(1)), i == fresh_at);
	endtask

	function automatic void add_text(input string s, input logic mix_case);
		int i;
		logic [7:0] c;
		for (i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
					$urandom_range(1))
				c = c ^ 8'h20;
			line_buf.push_back(c);
		end
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(3) == 0) ? 8'($urandom_range(13, 9)) : 8'h20;
	endfunction

	function automatic void add_value();
		int i;
		int n;
		n = $urandom_range(12);
		for (i = 0; i < n; i++)
			line_buf.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
				8'($urandom_range(126, 32)));
	endfunction

	function automatic string pick_name();
		case ($urandom_range(10))
			0:       return "From";
			1:       return "Subject";
			2:       return "To";
			3:       return "Cc";
			4:       return "Bcc";
			5:       return "X-Mailer";
			6:       return "Tox";
			7:       return "Fro";
			8:       return "Reply-To";
			9:       return "Subjects";
			default: return "Received";
		endcase
	endfunction

	function automatic void build_line();
		int i;
		int n;
		int r;
		line_buf.delete();
		r = $urandom_range(99);
		if (r < 55) begin
			add_text(pick_name(), 1'b1);
			line_buf.push_back(mhlc_pkg::COLON);
			n = $urandom_range(9);
			if (n < 6) begin
				line_buf.push_back(blank_char());
				add_value();
			end else if (n < 8) begin
				line_buf.push_back(8'($urandom_range(126, 33)));
				add_value();
			end
		end else if (r < 70) begin
			line_buf.push_back(blank_char());
			add_value();
		end else if (r < 85) begin
			n = $urandom_range(20, 12);
			for (i = 0; i < n; i++)
				line_buf.push_back(8'($urandom_range("z", "a")) ^
					8'($urandom_range(1) << 5));
			line_buf.push_back(mhlc_pkg::COLON);
			line_buf.push_back(blank_char());
			add_value();
		end else begin
			n = $urandom_range(8, 1);
			for (i = 0; i < n; i++)
				line_buf.push_back(8'($urandom_range(255)));
		end
	endfunction

	task automatic send_text(input string s, input logic mark, input int fresh_at);
		line_buf.delete();
		add_text(s, 1'b0);
		send_line(mark, fresh_at);
	endtask

	task automatic send_bytes(input logic [7:0] a, input logic [7:0] b, input int n);
		line_buf.delete();
		line_buf.push_back(a);
		if (n > 1)
			line_buf.push_back(b);
		send_line(1'b0, NO_NEW_MESSAGE);
	endtask

	initial begin
		int r;
		int fresh_at;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_text(":", 1'b0, 0);
		send_text("To:", 1'b0, NO_NEW_MESSAGE);
		send_bytes(8'h09, 8'h00, 1);
		send_text(" ", 1'b1, NO_NEW_MESSAGE);
		send_text("a b", 1'b0, NO_NEW_MESSAGE);
		send_bytes("a", 8'h7F, 2);
		send_text("x", 1'b0, NO_NEW_MESSAGE);
		send_bytes(8'hFF, 8'h00, 1);
		send_bytes(8'h00, 8'h00, 1);
		send_text("c:d", 1'b0, NO_NEW_MESSAGE);
		send_text("~: ", 1'b1, NO_NEW_MESSAGE);
		send_text("FROM:", 1'b0, 2);

		while (chars_sent < CHAR_TARGET) begin
			quiet = (chars_sent >= QUIET_FROM) && (chars_sent < QUIET_TO);
			build_line();
			r = $urandom_range(19);
			if (r < 3)
				fresh_at = 0;
			else if (r == 3)
				fresh_at = $urandom_range(line_buf.size() - 1);
			else
				fresh_at = NO_NEW_MESSAGE;
			send_line(1'($urandom_range(1)), fresh_at);
		end
		quiet = 1'b0;
		in_valid = 1'b0;

		while (lines_open != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
